// File: sv/mwmv_pkg.sv
`timescale 1ns / 1ps
package mwmv_pkg;

  // field widths
  localparam int KNOT_W   = 24;
  localparam int WEIGHT_W = 24;
  localparam int TOTAL_W  = 30;
  localparam int SIGMA_W  = 24;
  localparam int MEAN_W   = 24;
  localparam int VAR_W    = 48;
  localparam int FRAC_W   = 16;

  // internal product widths after the 16-bit fraction cut
  localparam int PROD_W = 32;
  localparam int SQ_W   = 32;
  localparam int WSQ_W  = 40;

  // shared divider step counter, counts up to VAR_W steps
  localparam int DIV_CNT_W = 6;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_SIGMA = 1'b0;
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 24'd65536;

  localparam int MAX_KNOTS_DEF = 64;

endpackage

// File: sv/mwmv_in_if.sv
`timescale 1ns / 1ps
interface mwmv_in_if import mwmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [KNOT_W-1:0]   knot;
  logic        [WEIGHT_W-1:0] weight;
  logic        [TOTAL_W-1:0]  weight_total;
  logic                       last;

  modport source (output valid, knot, weight, weight_total, last, input ready);
  modport sink (input valid, knot, weight, weight_total, last, output ready);
endinterface

// File: sv/mwmv_out_if.sv
`timescale 1ns / 1ps
interface mwmv_out_if import mwmv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean;
  logic        [VAR_W-1:0]  variance;
  logic                     divide_error;
  logic                     capacity_overflow;

  modport source (output valid, mean, variance, divide_error, capacity_overflow, input ready);
  modport sink (input valid, mean, variance, divide_error, capacity_overflow, output ready);
endinterface

// File: sv/mwmv_ram.sv
`timescale 1ns / 1ps
module mwmv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/mixture_weighted_mean_variance.sv
`timescale 1ns / 1ps
// Loading: one knot per cycle while in the load state; each transfer with room left writes the knot store
// and feeds a w*x accumulator. After the transfer marked last, the result is set by two passes of the
// shared one-bit-per-cycle divider (24-bit mean quotient, 48-bit variance quotient; passes are skipped on
// overflow or zero total) and one store read per knot. Loading of the next margin may start while the
// result waits in the output register.
// Reset (rst_ni low, async): margin sum, count and flags cleared, sigma = 1.0; store not cleared.
module mixture_weighted_mean_variance import mwmv_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mwmv_in_if.sink            in_i,
  mwmv_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W  = $clog2(MAX_KNOTS);
  localparam int CNT_W  = $clog2(MAX_KNOTS + 1);
  localparam int SUM_W  = PROD_W + IDX_W;
  localparam int ACC_W  = WSQ_W + IDX_W;
  localparam int MSH    = MEAN_W - FRAC_W;
  localparam int VSH    = VAR_W - FRAC_W;
  localparam int MHI_W  = SUM_W - MSH;
  localparam int VHI_W  = ACC_W - VSH;
  localparam int MCMP_W = (MHI_W > TOTAL_W) ? MHI_W : TOTAL_W;
  localparam int VCMP_W = (VHI_W > TOTAL_W) ? VHI_W : TOTAL_W;
  localparam int RAM_W  = KNOT_W + WEIGHT_W;

  localparam logic [MEAN_W-1:0] NEG_LIM = {1'b1, {(MEAN_W-1){1'b0}}};
  localparam logic [MEAN_W-1:0] POS_LIM = {1'b0, {(MEAN_W-1){1'b1}}};

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_MCHK  = 4'd2;
  localparam logic [3:0] S_MDIV  = 4'd3;
  localparam logic [3:0] S_MEND  = 4'd4;
  localparam logic [3:0] S_VPASS = 4'd5;
  localparam logic [3:0] S_VCHK  = 4'd6;
  localparam logic [3:0] S_VDIV  = 4'd7;
  localparam logic [3:0] S_VEND  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;

  // configuration
  logic [SIGMA_W-1:0]   sigma_q;
  logic [2*SIGMA_W-1:0] sigma_sq;
  logic [SQ_W-1:0]      sigsq_q;

  // loading
  logic                      in_acc, store;
  logic [KNOT_W-1:0]         magx;
  logic [KNOT_W+WEIGHT_W-1:0] prodx;
  logic [PROD_W-1:0]         pmag;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic                      prod_vld_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      ovf_q;
  logic [TOTAL_W-1:0]        total_q;

  // mean
  logic [SUM_W-1:0]         sum_mag;
  logic [MHI_W-1:0]         mhi;
  logic                     movf;
  logic                     neg_q;
  logic [MEAN_W-1:0]        mquo, mclip;
  logic signed [MEAN_W-1:0] mean_fin, mean_q;

  // shared divider: remainder plus shift register holding dividend low bits and quotient
  logic [TOTAL_W-1:0]   rem_q, rem_nxt;
  logic [VAR_W-1:0]     sh_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic [TOTAL_W:0]     dt, dsub;
  logic                 dge;

  // variance pass
  logic [CNT_W-1:0]           rd_idx_q;
  logic                       issue, pass_done;
  logic                       v1_q, v2_q, v3_q;
  logic [RAM_W-1:0]           rdata;
  logic signed [KNOT_W-1:0]   rd_knot;
  logic [WEIGHT_W-1:0]        rd_weight;
  logic signed [KNOT_W:0]     dx;
  logic [KNOT_W:0]            magd;
  logic [2*KNOT_W-1:0]        sqp;
  logic [WEIGHT_W-1:0]        w2_q;
  logic [SQ_W-1:0]            sq_q;
  logic [WEIGHT_W+SQ_W-1:0]   wsqp;
  logic [WSQ_W-1:0]           wsq_q;
  logic [ACC_W-1:0]           acc_q;
  logic [VHI_W-1:0]           vhi;
  logic                       vovf;
  logic [VAR_W:0]             vsum;
  logic [VAR_W-1:0]           var_fin, var_q;
  logic                       derr_q;

  // output register
  logic                     out_free, out_load;
  logic                     out_vld_q;
  logic signed [MEAN_W-1:0] out_mean_q;
  logic [VAR_W-1:0]         out_var_q;
  logic                     out_derr_q, out_ovf_q;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_SIGMA) ? PDATA_W'(sigma_q) : '0;

  assign sigma_sq = sigma_q * sigma_q;

  // ---------------- knot store ----------------
  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign store      = in_acc && (cnt_q < CNT_W'(MAX_KNOTS));
  assign issue      = (state_q == S_VPASS) && (rd_idx_q < cnt_q);

  mwmv_ram #(
    .Width (RAM_W),
    .Depth (MAX_KNOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({in_i.knot, in_i.weight}),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign rd_knot   = rdata[RAM_W-1:WEIGHT_W];
  assign rd_weight = rdata[WEIGHT_W-1:0];

  // ---------------- datapath logic ----------------
  always_comb begin
    // w*x, cut toward zero
    magx   = in_i.knot[KNOT_W-1] ? KNOT_W'(-in_i.knot) : KNOT_W'(in_i.knot);
    prodx  = magx * in_i.weight;
    pmag   = prodx[KNOT_W+WEIGHT_W-1:FRAC_W];
    prod_d = in_i.knot[KNOT_W-1] ? -$signed(pmag) : $signed(pmag);

    // mean overflow when |sum| >= total * 2^8
    sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    mhi     = sum_mag[SUM_W-1:MSH];
    movf    = MCMP_W'(mhi) >= MCMP_W'(total_q);

    // one restoring step
    dt      = {rem_q, sh_q[VAR_W-1]};
    dsub    = dt - {1'b0, total_q};
    dge     = dt >= {1'b0, total_q};
    rem_nxt = dge ? dsub[TOTAL_W-1:0] : dt[TOTAL_W-1:0];

    mquo = sh_q[MEAN_W-1:0];
    if (neg_q) begin
      mclip    = (mquo > NEG_LIM) ? NEG_LIM : mquo;
      mean_fin = $signed(MEAN_W'(-mclip));
    end else begin
      mclip    = (mquo > POS_LIM) ? POS_LIM : mquo;
      mean_fin = $signed(mclip);
    end

    // squared deviation stage
    dx   = {rd_knot[KNOT_W-1], rd_knot} - {mean_q[MEAN_W-1], mean_q};
    magd = dx[KNOT_W] ? (KNOT_W+1)'(-dx) : (KNOT_W+1)'(dx);
    sqp  = magd[KNOT_W-1:0] * magd[KNOT_W-1:0];
    wsqp = w2_q * sq_q;

    vhi  = acc_q[ACC_W-1:VSH];
    vovf = VCMP_W'(vhi) >= VCMP_W'(total_q);

    vsum    = {1'b0, sh_q} + (VAR_W+1)'(sigsq_q);
    var_fin = vsum[VAR_W] ? {VAR_W{1'b1}} : vsum[VAR_W-1:0];

    pass_done = (rd_idx_q == cnt_q) && !v1_q && !v2_q && !v3_q;
  end

  assign out_free = !out_vld_q || out_o.ready;
  assign out_load = (state_q == S_OUT) && out_free;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:  if (in_acc && in_i.last) state_d = S_SUM;
      S_SUM:   state_d = S_MCHK;
      S_MCHK: begin
        if (total_q == '0) state_d = S_OUT;
        else if (movf)     state_d = S_MEND;
        else               state_d = S_MDIV;
      end
      S_MDIV:  if (dcnt_q == DIV_CNT_W'(1)) state_d = S_MEND;
      S_MEND:  state_d = S_VPASS;
      S_VPASS: if (pass_done) state_d = S_VCHK;
      S_VCHK:  state_d = vovf ? S_VEND : S_VDIV;
      S_VDIV:  if (dcnt_q == DIV_CNT_W'(1)) state_d = S_VEND;
      S_VEND:  state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_LOAD;
      default: state_d = S_LOAD;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      sigma_q    <= SIGMA_RESET;
      sum_q      <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      prod_vld_q <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_SIGMA)) begin
        sigma_q <= pwdata[SIGMA_W-1:0];
      end

      prod_vld_q <= store;
      if (out_load) begin
        sum_q <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        if (prod_vld_q) sum_q <= sum_q + SUM_W'(prod_q);
        if (store)      cnt_q <= cnt_q + CNT_W'(1);
        if (in_acc && !store) ovf_q <= 1'b1;
      end

      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;

      if (out_load)         out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sigsq_q <= sigma_sq[2*SIGMA_W-1:FRAC_W];
    prod_q  <= prod_d;
    w2_q    <= rd_weight;
    sq_q    <= sqp[2*KNOT_W-1:FRAC_W];
    wsq_q   <= wsqp[WEIGHT_W+SQ_W-1:FRAC_W];

    if (in_acc && in_i.last) total_q <= in_i.weight_total;

    if (state_q == S_MEND) acc_q <= '0;
    else if (v3_q)         acc_q <= acc_q + ACC_W'(wsq_q);

    if (issue) rd_idx_q <= rd_idx_q + CNT_W'(1);

    case (state_q)
      S_MCHK: begin
        neg_q  <= sum_q[SUM_W-1];
        rem_q  <= TOTAL_W'(mhi);
        sh_q   <= movf ? {VAR_W{1'b1}}
                       : {sum_mag[MSH-1:0], {FRAC_W{1'b0}}, {(VAR_W-MEAN_W){1'b0}}};
        dcnt_q <= DIV_CNT_W'(MEAN_W);
        mean_q <= '0;
        var_q  <= '0;
        derr_q <= (total_q == '0);
      end
      S_MDIV, S_VDIV: begin
        rem_q  <= rem_nxt;
        sh_q   <= {sh_q[VAR_W-2:0], dge};
        dcnt_q <= dcnt_q - DIV_CNT_W'(1);
      end
      S_MEND: begin
        mean_q   <= mean_fin;
        rd_idx_q <= '0;
      end
      S_VCHK: begin
        rem_q  <= TOTAL_W'(vhi);
        sh_q   <= vovf ? {VAR_W{1'b1}} : {acc_q[VSH-1:0], {FRAC_W{1'b0}}};
        dcnt_q <= DIV_CNT_W'(VAR_W);
      end
      S_VEND: var_q <= var_fin;
      default: ;
    endcase

    if (out_load) begin
      out_mean_q <= mean_q;
      out_var_q  <= var_q;
      out_derr_q <= derr_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.mean              = out_mean_q;
  assign out_o.variance          = out_var_q;
  assign out_o.divide_error      = out_derr_q;
  assign out_o.capacity_overflow = out_ovf_q;

endmodule
